// ----- sv/tch_pkg.sv -----
// Shared types, constants and tables of the tilt-compensated heading pipeline.
package tch_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_CELLS   = 32;
   localparam int DIV_CELLS    = 31;
   localparam int SIDE_W       = 96;

   localparam logic [1:0] REG_REF_X = 2'd0;
   localparam logic [1:0] REG_REF_Y = 2'd1;
   localparam logic [1:0] REG_REF_Z = 2'd2;

   localparam logic [31:0] HALF_TURN      = 32'h8000_0000;
   localparam logic [14:0] HEADING_FAIL   = 15'd32000;
   localparam logic [14:0] UNITS_PER_TURN = 15'd23040;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef struct packed {
      logic valid;
      logic fail;
      logic degen;
      logic zero;
   } tag_type;

   typedef struct packed {
      tag_type            tag;
      logic [SIDE_W-1:0]  side;
      logic [2:0]         neg;
      logic [2:0][31:0]   mag;
      logic [63:0]        rad;
      logic [33:0]        rem;
      logic [31:0]        root;
   } sq_type;

   typedef struct packed {
      tag_type            tag;
      logic [SIDE_W-1:0]  side;
      logic [2:0]         neg;
      logic [31:0]        den;
      logic [2:0][31:0]   rem;
      logic [2:0][30:0]   dbits;
      logic [2:0][30:0]   quo;
   } dv_type;

   typedef struct packed {
      tag_type             tag;
      logic [4:0]          idx;
      logic signed [37:0]  x;
      logic signed [37:0]  y;
      logic [31:0]         z;
   } cd_type;

endpackage

// ----- sv/tch_sqrt_cell.sv -----
// One cell of the square-root chain: settles one root bit per cell.
module tch_sqrt_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  tch_pkg::sq_type d_in,
   output tch_pkg::sq_type d_out
);
   import tch_pkg::*;

   sq_type     q_ff, q_in;
   logic [33:0] rem2, trial;

   always_comb begin
      q_in  = d_in;
      rem2  = {d_in.rem[31:0], d_in.rad[63:62]};
      trial = {d_in.root, 2'b01};
      q_in.rad = {d_in.rad[61:0], 2'b00};
      if (rem2 >= trial) begin
         q_in.rem  = rem2 - trial;
         q_in.root = {d_in.root[30:0], 1'b1};
      end else begin
         q_in.rem  = rem2;
         q_in.root = {d_in.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.tag.valid <= 1'b0;
      end else if (adv) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;
endmodule

// ----- sv/tch_div_cell.sv -----
// One cell of the divider chain: one quotient bit for each of three lanes.
module tch_div_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  tch_pkg::dv_type d_in,
   output tch_pkg::dv_type d_out
);
   import tch_pkg::*;

   dv_type      q_ff, q_in;
   logic [32:0] r2 [3];
   logic [32:0] diff [3];

   always_comb begin
      q_in = d_in;
      for (int i = 0; i < 3; i++) begin
         r2[i]   = {d_in.rem[i], d_in.dbits[i][30]};
         diff[i] = r2[i] - {1'b0, d_in.den};
         q_in.dbits[i] = {d_in.dbits[i][29:0], 1'b0};
         if (r2[i] >= {1'b0, d_in.den}) begin
            q_in.rem[i] = diff[i][31:0];
            q_in.quo[i] = {d_in.quo[i][29:0], 1'b1};
         end else begin
            q_in.rem[i] = r2[i][31:0];
            q_in.quo[i] = {d_in.quo[i][29:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.tag.valid <= 1'b0;
      end else if (adv) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;
endmodule

// ----- sv/tch_cordic_cell.sv -----
// One CORDIC vectoring cell: rotates toward the x axis by one table angle.
module tch_cordic_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  tch_pkg::cd_type d_in,
   output tch_pkg::cd_type d_out
);
   import tch_pkg::*;

   cd_type             q_ff, q_in;
   logic signed [37:0] x, y, xs, ys;

   always_comb begin
      q_in = d_in;
      x  = d_in.x;
      y  = d_in.y;
      xs = x >>> d_in.idx;
      ys = y >>> d_in.idx;
      if (y > 0) begin
         q_in.x = x + ys;
         q_in.y = y - xs;
         q_in.z = d_in.z + ATAN_TAB[d_in.idx];
      end else begin
         q_in.x = x - ys;
         q_in.y = y + xs;
         q_in.z = d_in.z - ATAN_TAB[d_in.idx];
      end
      q_in.idx = d_in.idx + 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.tag.valid <= 1'b0;
      end else if (adv) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;
endmodule

// ----- sv/tch_norm.sv -----
// Vector normalizer: squares, sum, square-root chain, then divider chain to Q2.30.
module tch_norm (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  tch_pkg::tag_type                tag_in,
   input  logic [tch_pkg::SIDE_W-1:0]      side_in,
   input  logic [2:0][32:0]                vec_in,
   output tch_pkg::tag_type                tag_out,
   output logic [tch_pkg::SIDE_W-1:0]      side_out,
   output logic [2:0][31:0]                unit_out
);
   import tch_pkg::*;

   tag_type            tag1_ff, tag2_ff;
   logic [SIDE_W-1:0]  side1_ff, side2_ff;
   logic [2:0]         neg1_ff, neg2_ff;
   logic [2:0][31:0]   mag1_ff, mag2_ff, mag1_in;
   logic [2:0][63:0]   sq2_ff;
   logic [63:0]        ss;
   sq_type             s3_ff, s3_in;
   sq_type             sq_chain [SQRT_CELLS+1];
   dv_type             dv_chain [DIV_CELLS+1];
   logic [32:0]        absv [3];
   dv_type             dv_last;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         absv[i]    = vec_in[i][32] ? (33'd0 - vec_in[i]) : vec_in[i];
         mag1_in[i] = absv[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
      end else if (adv) begin
         tag1_ff  <= tag_in;
         side1_ff <= side_in;
         neg1_ff  <= {vec_in[2][32], vec_in[1][32], vec_in[0][32]};
         mag1_ff  <= mag1_in;
         tag2_ff  <= tag1_ff;
         side2_ff <= side1_ff;
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= 64'(mag1_ff[i]) * 64'(mag1_ff[i]);
         end
      end
   end

   assign ss = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];

   always_comb begin
      s3_in           = '0;
      s3_in.tag       = tag2_ff;
      s3_in.tag.degen = tag2_ff.degen | (ss == 64'd0);
      s3_in.side      = side2_ff;
      s3_in.neg       = neg2_ff;
      s3_in.mag       = mag2_ff;
      s3_in.rad       = ss;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.tag.valid <= 1'b0;
      end else if (adv) begin
         s3_ff <= s3_in;
      end
   end

   assign sq_chain[0] = s3_ff;

   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      tch_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .d_in  (sq_chain[g]),
         .d_out (sq_chain[g+1])
      );
   end

   // Dividend is |v| << 30; the top 31 bits start the remainder.
   always_comb begin
      dv_chain[0]      = '0;
      dv_chain[0].tag  = sq_chain[SQRT_CELLS].tag;
      dv_chain[0].side = sq_chain[SQRT_CELLS].side;
      dv_chain[0].neg  = sq_chain[SQRT_CELLS].neg;
      dv_chain[0].den  = sq_chain[SQRT_CELLS].root;
      for (int i = 0; i < 3; i++) begin
         dv_chain[0].rem[i]   = {1'b0, sq_chain[SQRT_CELLS].mag[i][31:1]};
         dv_chain[0].dbits[i] = {sq_chain[SQRT_CELLS].mag[i][0], 30'd0};
      end
   end

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      tch_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .d_in  (dv_chain[g]),
         .d_out (dv_chain[g+1])
      );
   end

   assign dv_last  = dv_chain[DIV_CELLS];
   assign tag_out  = dv_last.tag;
   assign side_out = dv_last.side;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unit_out[i] = dv_last.neg[i] ? (32'd0 - {1'b0, dv_last.quo[i]})
                                      : {1'b0, dv_last.quo[i]};
      end
   end
endmodule

// ----- sv/tilt_compensated_heading.sv -----
// Tilt-compensated compass heading: one magnetometer and accelerometer sample in,
// one heading out.
//
// Input channel req_: tdata carries the six 16-bit signed axes, tuser the
// read-failure flag. Result channel rsp_: tdata carries the heading in 1/64
// degree (15 bits) and the degenerate flag. Configuration: csr_we writes
// csr_wdata into reference-axis component csr_addr (x, y, z).
// Every stage is a register; the normalizers are chains of square-root and
// divider cells (32 and 31 cells), the arctangent a chain of 16 CORDIC cells.
// A new sample is taken in every cycle unless the output is stalled:
// throughput is one transaction per clock.
// A read failure yields heading 32000; a zero-length cross product yields
// heading 0 with degenerate set.
// Reset empties the pipeline and sets the reference axis to (1,0,0).
// While rsp_tvalid is high and rsp_tready low, the whole chain holds and
// req_tready drops; the held result stays on rsp_tdata.
module tilt_compensated_heading (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // mag_x, mag_y, mag_z, accel_x, accel_y, accel_z
   input  logic        req_tuser,  // read_failed
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // heading[14:0], degenerate
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [1:0]  csr_wdata
);
   import tch_pkg::*;

   logic              adv;
   logic [1:0]        ref_ff [3];
   tag_type           tag0_ff, tag1_ff, tagn_ff, tagp_ff, tagm_ff;
   logic [2:0][15:0]  m0_ff, a0_ff, a1_ff;
   logic [5:0][31:0]  pe1_ff;
   logic [2:0][32:0]  vec_e, vec_n;
   tag_type           tag_e, tag_n;
   logic [SIDE_W-1:0] side_e, side_n;
   logic [2:0][31:0]  eu, nu, eun_ff;
   logic [5:0][47:0]  pn_ff;
   logic signed [48:0] nd [3];
   logic signed [48:0] na [3];
   logic signed [35:0] ex_in, nx_in, ex_ff, nx_ff;
   cd_type            cd_chain [CORDIC_STEPS+1];
   logic [46:0]       pm_ff;
   logic [47:0]       hsum;
   logic [15:0]       hraw, hwrap;
   logic              rsp_tvalid_ff;
   logic [15:0]       rsp_tdata_ff;
   logic [14:0]       heading;
   logic              degenerate;

   function automatic logic signed [35:0] scale(input logic signed [31:0] v,
                                                input logic [1:0] r);
      logic signed [35:0] w;
      begin
         w = 36'(v);
         case (r)
            2'b01:   scale = w;
            2'b11:   scale = -w;
            2'b10:   scale = -(w <<< 1);
            default: scale = '0;
         endcase
      end
   endfunction

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff[0] <= 2'b01;
         ref_ff[1] <= 2'b00;
         ref_ff[2] <= 2'b00;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_REF_X: ref_ff[0] <= csr_wdata;
            REG_REF_Y: ref_ff[1] <= csr_wdata;
            REG_REF_Z: ref_ff[2] <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // Capture and East cross products
   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff.valid <= 1'b0;
         tag1_ff.valid <= 1'b0;
      end else if (adv) begin
         tag0_ff <= '{valid: req_tvalid, fail: req_tuser, degen: 1'b0, zero: 1'b0};
         m0_ff   <= req_tdata[47:0];
         a0_ff   <= req_tdata[95:48];
         tag1_ff <= tag0_ff;
         a1_ff   <= a0_ff;
         pe1_ff[0] <= $signed(m0_ff[1]) * $signed(a0_ff[2]);
         pe1_ff[1] <= $signed(m0_ff[2]) * $signed(a0_ff[1]);
         pe1_ff[2] <= $signed(m0_ff[2]) * $signed(a0_ff[0]);
         pe1_ff[3] <= $signed(m0_ff[0]) * $signed(a0_ff[2]);
         pe1_ff[4] <= $signed(m0_ff[0]) * $signed(a0_ff[1]);
         pe1_ff[5] <= $signed(m0_ff[1]) * $signed(a0_ff[0]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vec_e[i] = {pe1_ff[2*i][31], pe1_ff[2*i]} - {pe1_ff[2*i+1][31], pe1_ff[2*i+1]};
      end
   end

   tch_norm u_norm_e (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .tag_in   (tag1_ff),
      .side_in  ({48'd0, a1_ff}),
      .vec_in   (vec_e),
      .tag_out  (tag_e),
      .side_out (side_e),
      .unit_out (eu)
   );

   // North = a x East_unit, scaled down by 2^15
   always_ff @(posedge clock) begin
      if (reset) begin
         tagn_ff.valid <= 1'b0;
      end else if (adv) begin
         tagn_ff  <= tag_e;
         eun_ff   <= eu;
         pn_ff[0] <= $signed(side_e[31:16]) * $signed(eu[2]);
         pn_ff[1] <= $signed(side_e[47:32]) * $signed(eu[1]);
         pn_ff[2] <= $signed(side_e[47:32]) * $signed(eu[0]);
         pn_ff[3] <= $signed(side_e[15:0])  * $signed(eu[2]);
         pn_ff[4] <= $signed(side_e[15:0])  * $signed(eu[1]);
         pn_ff[5] <= $signed(side_e[31:16]) * $signed(eu[0]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nd[i] = $signed({pn_ff[2*i][47], pn_ff[2*i]})
               - $signed({pn_ff[2*i+1][47], pn_ff[2*i+1]});
         // truncate toward zero
         na[i] = (nd[i] < 0) ? (nd[i] + 49'sd32767) : nd[i];
         na[i] = na[i] >>> 15;
         vec_n[i] = na[i][32:0];
      end
   end

   tch_norm u_norm_n (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .tag_in   (tagn_ff),
      .side_in  (eun_ff),
      .vec_in   (vec_n),
      .tag_out  (tag_n),
      .side_out (side_n),
      .unit_out (nu)
   );

   // Project both unit vectors onto the reference axis
   always_comb begin
      ex_in = scale(side_n[31:0], ref_ff[0]) + scale(side_n[63:32], ref_ff[1])
            + scale(side_n[95:64], ref_ff[2]);
      nx_in = scale(nu[0], ref_ff[0]) + scale(nu[1], ref_ff[1])
            + scale(nu[2], ref_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tagp_ff.valid <= 1'b0;
      end else if (adv) begin
         tagp_ff <= '{valid: tag_n.valid, fail: tag_n.fail, degen: tag_n.degen,
                      zero: (ex_in == 36'sd0) && (nx_in == 36'sd0)};
         ex_ff   <= ex_in;
         nx_ff   <= nx_in;
      end
   end

   // Pre-rotate by a half turn when North projection is negative
   always_comb begin
      cd_chain[0].tag = tagp_ff;
      cd_chain[0].idx = 5'd0;
      if (nx_ff < 0) begin
         cd_chain[0].x = -38'(nx_ff);
         cd_chain[0].y = -38'(ex_ff);
         cd_chain[0].z = HALF_TURN;
      end else begin
         cd_chain[0].x = 38'(nx_ff);
         cd_chain[0].y = 38'(ex_ff);
         cd_chain[0].z = 32'd0;
      end
   end

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      tch_cordic_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .d_in  (cd_chain[g]),
         .d_out (cd_chain[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tagm_ff.valid <= 1'b0;
      end else if (adv) begin
         tagm_ff <= cd_chain[CORDIC_STEPS].tag;
         pm_ff   <= 47'(cd_chain[CORDIC_STEPS].z) * 47'(UNITS_PER_TURN);
      end
   end

   // Round to 1/64 degree and wrap a full turn to zero
   always_comb begin
      hsum  = {1'b0, pm_ff} + 48'(HALF_TURN);
      hraw  = hsum[47:32];
      hwrap = (hraw >= 16'(UNITS_PER_TURN)) ? (hraw - 16'(UNITS_PER_TURN)) : hraw;
      if (tagm_ff.fail) begin
         heading    = HEADING_FAIL;
         degenerate = 1'b0;
      end else if (tagm_ff.degen) begin
         heading    = 15'd0;
         degenerate = 1'b1;
      end else if (tagm_ff.zero) begin
         heading    = 15'd0;
         degenerate = 1'b0;
      end else begin
         heading    = hwrap[14:0];
         degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= tagm_ff.valid;
         rsp_tdata_ff  <= {degenerate, heading};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
endmodule

// ----- sv/tch_checker.sv -----
// Port-level checks for the heading block, bound to its top level.
module tch_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_stall_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15] |-> rsp_tdata[14:0] == 15'd0)
      else $error("degenerate result with nonzero heading");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:0] < 15'd23040 || rsp_tdata[14:0] == 15'd32000)
      else $error("heading out of range");
endmodule

bind tilt_compensated_heading tch_checker u_tch_checker (.*);
